[hdl/assert_macros.svh]
// assertion macros shared by the contrast stretch rtl
// no dependencies; expects signals named clock and reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked at every rising clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[hdl/lcs_pkg.sv]
// shared constants for the linear contrast stretch block
// no dependencies
`timescale 1ns / 1ps

package lcs_pkg;

   // output gray level and configuration register width
   localparam int OUT_BITS   = 8;
   // fault code width
   localparam int FAULT_BITS = 2;
   // configuration register index width
   localparam int CSR_INDEX_BITS = 1;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_MIN = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_MAX = 1'd1;

   // fault codes
   localparam logic [FAULT_BITS-1:0] FAULT_OK    = 2'd0;
   localparam logic [FAULT_BITS-1:0] FAULT_FLAT  = 2'd1;
   localparam logic [FAULT_BITS-1:0] FAULT_RANGE = 2'd2;

   // operation codes
   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_MAP     = 1'b1;

   // reset values of the output range registers
   localparam logic [OUT_BITS-1:0] OUT_MIN_RESET = 8'd0;
   localparam logic [OUT_BITS-1:0] OUT_MAX_RESET = 8'd255;

   // serial arithmetic: radix-4 multiplier steps, saturating quotient width
   localparam int MUL_STEPS = OUT_BITS / 2;
   localparam int QUO_BITS  = OUT_BITS + 1;

   // highest output level, in the width of the final add
   localparam logic [OUT_BITS+1:0] LEVEL_CLAMP = 10'd255;

endpackage

[hdl/lcs_req_if.sv]
// valid/ready channel interfaces of the contrast stretch block
// depends on lcs_pkg
`timescale 1ns / 1ps

interface lcs_req_if
   import lcs_pkg::*;
#(
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic                  first;
   logic [PIXEL_BITS-1:0] pixel;

   modport source (output valid, output op, output first, output pixel, input ready);
   modport sink   (input valid, input op, input first, input pixel, output ready);
endinterface

interface lcs_rsp_if
   import lcs_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [OUT_BITS-1:0]   pixel_out;
   logic [FAULT_BITS-1:0] fault;

   modport source (output valid, output pixel_out, output fault, input ready);
   modport sink   (input valid, input pixel_out, input fault, output ready);
endinterface

[hdl/linear_contrast_stretch.sv]
// linear min-max contrast stretch: running range tracker, serial multiplier and divider
// depends on lcs_pkg, lcs_req_if/lcs_rsp_if and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Two-pass gray-level contrast stretch. Measure transactions (op = 0) fold the
// pixel into a running darkest/brightest range; first = 1 clears the range
// before the fold. Measure transactions give no response.
// Map transactions (op = 1) give one response:
//   out_min + round((pixel - darkest) * (out_max - out_min) / (brightest - darkest))
// with exact rounding (ties toward plus infinity) and clamping to 0..255.
// When out_min >= out_max the response is out_min with fault 2; otherwise when
// brightest <= darkest it is out_min with fault 1. These fault responses are
// ready the cycle after acceptance. A normal map transaction captures its
// operands at the accepting edge, then runs the radix-4 serial multiplier, a
// step that applies the rounding offset and sign, the range check, the
// restoring divider (one quotient bit a cycle) and a step that clamps and
// loads the response register; a quotient that exceeds 9 bits skips the
// divider since the result clamps anyway. The final step waits while an
// earlier response still sits in the response register. One map transaction
// is in flight at a time, so the next transaction is taken at the earliest
// in the cycle after the response is loaded. A new transaction is taken
// while the response register is empty or its content is being taken in the
// same cycle. Registers out_min (index 0) and out_max (index 1) are written
// through the csr port; the user must write them only while the block is
// idle, which the block itself does not enforce.
module linear_contrast_stretch
   import lcs_pkg::*;
#(
   parameter int PIXEL_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   lcs_req_if.sink                   req,
   lcs_rsp_if.source                 rsp,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [OUT_BITS-1:0]       csr_wdata
);

   // product register: high part accumulates, low part holds the multiplier
   localparam int PW = PIXEL_BITS + OUT_BITS;
   // dividend register: high part seeds the remainder, low part gives quotient bits
   localparam int MW = PIXEL_BITS + QUO_BITS;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_OVF  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [OUT_BITS-1:0]     out_min_ff, out_min_in;
   logic [OUT_BITS-1:0]     out_max_ff, out_max_in;
   logic [PIXEL_BITS-1:0]   darkest_ff, darkest_in;
   logic [PIXEL_BITS-1:0]   brightest_ff, brightest_in;
   logic [PIXEL_BITS-1:0]   dist_ff, dist_in;
   logic                    neg_ff, neg_in;
   logic [PIXEL_BITS-1:0]   mag_ff, mag_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic [MW-1:0]           mw_ff, mw_in;
   logic [PIXEL_BITS-1:0]   rem_ff, rem_in;
   logic [QUO_BITS-1:0]     quo_ff, quo_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]     rsp_pixel_ff, rsp_pixel_in;
   logic [FAULT_BITS-1:0]   rsp_fault_ff, rsp_fault_in;

   // combinational helpers
   logic                    req_fire;
   logic                    slot_free;
   logic [PIXEL_BITS:0]     diff;
   logic [PIXEL_BITS:0]     diff_neg;
   logic [PIXEL_BITS-1:0]   dark_base;
   logic [PIXEL_BITS-1:0]   bright_base;
   logic [PIXEL_BITS+1:0]   pp;
   logic [PIXEL_BITS+1:0]   acc_sum;
   logic [MW-1:0]           p_x, h_x, d_x;
   logic [PIXEL_BITS-1:0]   hi_part;
   logic [PIXEL_BITS:0]     r2;
   logic                    r2_ge;
   logic [PIXEL_BITS:0]     r2_sub;
   logic [OUT_BITS+1:0]     omin_x, quo_x, pos_sum;
   logic [OUT_BITS-1:0]     level;

   // response register is free, or is emptied this cycle
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req.valid && req.ready;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.pixel_out = rsp_pixel_ff;
   assign rsp.fault     = rsp_fault_ff;

   // signed offset of the pixel from the darkest level, and its magnitude
   assign diff     = {1'b0, req.pixel} - {1'b0, darkest_ff};
   assign diff_neg = -diff;

   // radix-4 partial product: magnitude times the low multiplier digit
   always_comb begin
      case (prod_ff[1:0])
         2'd0:    pp = '0;
         2'd1:    pp = {2'b00, mag_ff};
         2'd2:    pp = {1'b0, mag_ff, 1'b0};
         default: pp = {2'b00, mag_ff} + {1'b0, mag_ff, 1'b0};
      endcase
   end
   assign acc_sum = {2'b00, prod_ff[PW-1:OUT_BITS]} + pp;

   // operands of the rounding step, all at dividend width
   assign p_x = {1'b0, prod_ff};
   assign d_x = {{(MW-PIXEL_BITS){1'b0}}, dist_ff};
   assign h_x = d_x >> 1;

   // restoring divider step
   assign hi_part = mw_ff[MW-1:QUO_BITS];
   assign r2      = {rem_ff, mw_ff[QUO_BITS-1]};
   assign r2_ge   = r2 >= {1'b0, dist_ff};
   assign r2_sub  = r2 - {1'b0, dist_ff};

   // final offset from out_min and clamp
   assign omin_x  = {2'b00, out_min_ff};
   assign quo_x   = {1'b0, quo_ff};
   assign pos_sum = omin_x + quo_x;
   always_comb begin
      if (neg_ff) begin
         if (quo_x > omin_x) begin
            level = '0;
         end else begin
            level = out_min_ff - quo_ff[OUT_BITS-1:0];
         end
      end else if (pos_sum > LEVEL_CLAMP) begin
         level = LEVEL_CLAMP[OUT_BITS-1:0];
      end else begin
         level = pos_sum[OUT_BITS-1:0];
      end
   end

   // range after an optional clear
   assign dark_base   = req.first ? '1 : darkest_ff;
   assign bright_base = req.first ? '0 : brightest_ff;

   always_comb begin
      state_in     = state_ff;
      out_min_in   = out_min_ff;
      out_max_in   = out_max_ff;
      darkest_in   = darkest_ff;
      brightest_in = brightest_ff;
      dist_in      = dist_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      mw_in        = mw_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_fault_in = rsp_fault_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_OUT_MIN: out_min_in = csr_wdata;
            CSR_OUT_MAX: out_max_in = csr_wdata;
            default:     ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.op == OP_MEASURE) begin
                  darkest_in   = (req.pixel < dark_base) ? req.pixel : dark_base;
                  brightest_in = (req.pixel > bright_base) ? req.pixel : bright_base;
               end else if (out_min_ff >= out_max_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_pixel_in = out_min_ff;
                  rsp_fault_in = FAULT_RANGE;
               end else if (brightest_ff <= darkest_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_pixel_in = out_min_ff;
                  rsp_fault_in = FAULT_FLAT;
               end else begin
                  // capture operands; multiplier is out_max - out_min
                  dist_in  = brightest_ff - darkest_ff;
                  neg_in   = diff[PIXEL_BITS];
                  mag_in   = diff[PIXEL_BITS] ? diff_neg[PIXEL_BITS-1:0]
                                              : diff[PIXEL_BITS-1:0];
                  prod_in  = {{PIXEL_BITS{1'b0}}, out_max_ff - out_min_ff};
                  cnt_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in = {acc_sum, prod_ff[OUT_BITS-1:2]};
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'(MUL_STEPS - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // add half the range for rounding; negative values become a
            // ceiling-adjusted magnitude so that the divider floors
            if (!neg_ff) begin
               mw_in = p_x + h_x;
            end else if (p_x <= h_x) begin
               mw_in  = h_x - p_x;
               neg_in = 1'b0;
            end else begin
               mw_in = p_x - h_x + d_x - {{(MW-1){1'b0}}, 1'b1};
            end
            state_in = ST_OVF;
         end
         ST_OVF: begin
            if (hi_part >= dist_ff) begin
               // quotient beyond nine bits clamps either way
               quo_in   = '1;
               state_in = ST_FIN;
            end else begin
               rem_in   = hi_part;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = r2_ge ? r2_sub[PIXEL_BITS-1:0] : r2[PIXEL_BITS-1:0];
            quo_in = {quo_ff[QUO_BITS-2:0], r2_ge};
            mw_in  = {mw_ff[MW-2:0], 1'b0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(QUO_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = level;
               rsp_fault_in = FAULT_OK;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_min_ff   <= OUT_MIN_RESET;
         out_max_ff   <= OUT_MAX_RESET;
         darkest_ff   <= '1;
         brightest_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_min_ff   <= out_min_in;
         out_max_ff   <= out_max_in;
         darkest_ff   <= darkest_in;
         brightest_ff <= brightest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dist_ff      <= dist_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      mw_ff        <= mw_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   // range only moves on accepted measure transactions
   `ASSERT_CLK(a_range_hold, !(req_fire && req.op == OP_MEASURE) |=> $stable(darkest_ff) && $stable(brightest_ff), "range changed without a measure transaction")

   // fault responses carry out_min
   `ASSERT_CLK(a_fault_level, rsp_valid_ff && rsp_fault_ff != FAULT_OK |-> rsp_pixel_ff == out_min_ff, "fault response level is not out_min")

   // divider remainder stays below the range
   `ASSERT_CLK(a_rem_bound, state_ff == ST_DIV |-> rem_ff < dist_ff, "divider remainder out of bound")

   // a response appears only after acceptance or the final step
   `ASSERT_CLK(a_rsp_source, $rose(rsp_valid_ff) |-> $past(req_fire) || $past(state_ff) == ST_FIN, "response without a source")

endmodule

[bench/tb_linear_contrast_stretch.sv]
// self-checking bench for the linear_contrast_stretch block
// depends on lcs_pkg, lcs_req_if/lcs_rsp_if and the rtl top level
`timescale 1ns / 1ps

module tb_linear_contrast_stretch;
   import lcs_pkg::*;

   localparam int PIXEL_BITS     = 8;
   localparam int CLOCK_HALF     = 10;
   localparam int RESET_CYCLES   = 9;
   // idle cycles before a csr write and after the last response
   localparam int SETTLE_CYCLES  = 20;
   localparam int DRAIN_CYCLES   = 40;
   // cycles with no transaction on either channel before giving up
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int IDLE_PERCENT   = 34;

   typedef struct packed {
      logic                  op;
      logic                  first;
      logic [PIXEL_BITS-1:0] pixel;
   } pixel_job_type;

   typedef struct packed {
      logic [OUT_BITS-1:0]   pixel_out;
      logic [FAULT_BITS-1:0] fault;
   } stretched_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [OUT_BITS-1:0]       csr_wdata;

   lcs_req_if #(.PIXEL_BITS(PIXEL_BITS)) req_if ();
   lcs_rsp_if rsp_if ();

   linear_contrast_stretch #(
      .PIXEL_BITS(PIXEL_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // pixels waiting to be sent, and stretched levels waiting to come back
   pixel_job_type pixel_jobs[$];
   stretched_type stretch_expect[$];
   pixel_job_type next_job;
   stretched_type seen_level;
   stretched_type want_level;

   // shadow of the output range registers and the running pixel range
   logic [OUT_BITS-1:0]   lo_level   = OUT_MIN_RESET;
   logic [OUT_BITS-1:0]   hi_level   = OUT_MAX_RESET;
   logic [PIXEL_BITS-1:0] range_dark   = '1;
   logic [PIXEL_BITS-1:0] range_bright = '0;

   int  issued_count   = 0;
   int  accepted_count = 0;
   int  fail_count     = 0;
   int  stall_cycles   = 0;
   // no random idling on either side while set
   logic steady = 1'b0;

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // expected response for a map transaction under the current range and registers
   function automatic stretched_type stretch_pixel(input logic [PIXEL_BITS-1:0] level);
      stretched_type res;
      int span;
      int numer;
      int quot;
      res.pixel_out = lo_level;
      res.fault     = FAULT_OK;
      if (lo_level >= hi_level) begin
         // bad output range wins over the flat image check
         res.fault = FAULT_RANGE;
      end else if (range_bright <= range_dark) begin
         // nothing measured yet, or a single gray level
         res.fault = FAULT_FLAT;
      end else begin
         span  = int'(range_bright) - int'(range_dark);
         numer = 2 * (int'(lo_level) * span
                 + (int'(level) - int'(range_dark)) * (int'(hi_level) - int'(lo_level)))
                 + span;
         // floor division, so that ties round toward plus infinity
         if (numer >= 0)
            quot = numer / (2 * span);
         else
            quot = -((-numer + 2 * span - 1) / (2 * span));
         if (quot < 0)
            quot = 0;
         if (quot > 255)
            quot = 255;
         res.pixel_out = quot[OUT_BITS-1:0];
      end
      return res;
   endfunction

   // request driver: holds a transaction until ready, idles at random between them
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.op    <= OP_MEASURE;
         req_if.first <= 1'b0;
         req_if.pixel <= '0;
      end else begin
         // transaction taken at this edge: update the prediction
         if (req_if.valid && req_if.ready) begin
            accepted_count++;
            if (req_if.op == OP_MAP) begin
               stretch_expect.push_back(stretch_pixel(req_if.pixel));
            end else begin
               if (req_if.first) begin
                  range_dark   = '1;
                  range_bright = '0;
               end
               if (req_if.pixel < range_dark)
                  range_dark = req_if.pixel;
               if (req_if.pixel > range_bright)
                  range_bright = req_if.pixel;
            end
         end
         if (!req_if.valid || req_if.ready) begin
            if (pixel_jobs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               next_job = pixel_jobs.pop_front();
               req_if.valid <= 1'b1;
               req_if.op    <= next_job.op;
               req_if.first <= next_job.first;
               req_if.pixel <= next_job.pixel;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: random backpressure, compare against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen_level.pixel_out = rsp_if.pixel_out;
            seen_level.fault     = rsp_if.fault;
            if (stretch_expect.size() == 0) begin
               $error("unexpected response: pixel_out %0d, fault %0d",
                      seen_level.pixel_out, seen_level.fault);
               fail_count++;
            end else begin
               want_level = stretch_expect.pop_front();
               if (seen_level.pixel_out !== want_level.pixel_out) begin
                  $error("pixel_out mismatch: expected %0d, actual %0d",
                         want_level.pixel_out, seen_level.pixel_out);
                  fail_count++;
               end
               if (seen_level.fault !== want_level.fault) begin
                  $error("fault mismatch: expected %0d, actual %0d",
                         want_level.fault, seen_level.fault);
                  fail_count++;
               end
            end
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL linear_contrast_stretch");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic push_job(input logic op, input logic first, input int pixel);
      pixel_job_type job;
      job.op    = op;
      job.first = first;
      job.pixel = pixel[PIXEL_BITS-1:0];
      pixel_jobs.push_back(job);
      issued_count++;
   endtask

   // block idle: every transaction taken and every response back
   task automatic wait_drained();
      while (accepted_count != issued_count || stretch_expect.size() != 0)
         @(negedge clock);
   endtask

   // csr writes only while idle; the shadow is updated as each write is driven
   task automatic write_range(input int lo, input int hi);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_OUT_MIN;
      csr_wdata <= lo[OUT_BITS-1:0];
      lo_level   = lo[OUT_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_OUT_MAX;
      csr_wdata <= hi[OUT_BITS-1:0];
      hi_level   = hi[OUT_BITS-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // one image: clear, measure a few pixels, map a few; with noise and broken frames
   task automatic queue_frame();
      int base;
      int spread;
      int n_meas;
      int n_map;
      int kind;
      kind   = $urandom_range(99);
      base   = $urandom_range(255);
      spread = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(255);
      n_meas = $urandom_range(1, 6);
      n_map  = $urandom_range(1, 8);
      if (kind < 15) begin
         // noise: fully random transactions
         repeat (n_meas + n_map)
            push_job(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(255));
         return;
      end
      for (int i = 0; i < n_meas; i++)
         // broken frame: keeps the previous range instead of clearing it
         push_job(OP_MEASURE, (i == 0) && (kind >= 25), base + $urandom_range(spread));
      for (int i = 0; i < n_map; i++) begin
         if ($urandom_range(1))
            push_job(OP_MAP, 1'($urandom_range(1)), base + $urandom_range(spread));
         else
            push_job(OP_MAP, 1'($urandom_range(1)), $urandom_range(255));
      end
   endtask

   task automatic run_phase(input int lo, input int hi, input int count, input logic calm);
      int target;
      write_range(lo, hi);
      steady = calm;
      target = issued_count + count;
      while (issued_count < target)
         queue_frame();
   endtask

   initial begin
      int lo;
      csr_we       = 1'b0;
      csr_index    = CSR_OUT_MIN;
      csr_wdata    = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset output range
      push_job(OP_MAP, 1'b0, 0);          // unmeasured image
      push_job(OP_MEASURE, 1'b1, 128);
      push_job(OP_MAP, 1'b0, 128);        // single gray level, flat image
      push_job(OP_MEASURE, 1'b0, 0);
      push_job(OP_MEASURE, 1'b0, 255);    // full range
      push_job(OP_MAP, 1'b0, 0);
      push_job(OP_MAP, 1'b0, 255);
      push_job(OP_MAP, 1'b0, 128);
      push_job(OP_MAP, 1'b1, 127);        // first flag ignored on map
      push_job(OP_MEASURE, 1'b1, 50);
      push_job(OP_MEASURE, 1'b0, 60);
      push_job(OP_MAP, 1'b0, 55);         // exact half, rounds up
      push_job(OP_MAP, 1'b0, 0);          // below range, saturates at 0
      push_job(OP_MAP, 1'b0, 255);        // above range, saturates at 255
      push_job(OP_MEASURE, 1'b1, 255);
      push_job(OP_MAP, 1'b0, 200);        // flat at the top level
      push_job(OP_MEASURE, 1'b1, 0);
      push_job(OP_MAP, 1'b0, 0);          // flat at the bottom level
      push_job(OP_MEASURE, 1'b0, 1);
      push_job(OP_MAP, 1'b0, 1);
      push_job(OP_MAP, 1'b0, 0);

      // random part over several output ranges, extremes and bad ranges included
      run_phase(0, 255, 90, 1'b0);
      run_phase(16, 235, 90, 1'b0);
      run_phase(255, 255, 40, 1'b0);      // empty range
      run_phase(200, 50, 40, 1'b0);       // inverted range
      run_phase(0, 1, 90, 1'b1);          // long stretch with no idling
      run_phase(254, 255, 90, 1'b0);
      run_phase(0, 0, 40, 1'b0);
      lo = $urandom_range(200);
      run_phase(lo, $urandom_range(lo + 1, 255), 90, 1'b0);
      lo = $urandom_range(200);
      run_phase(lo, $urandom_range(lo + 1, 255), 90, 1'b0);
      run_phase(0, 255, 40, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS linear_contrast_stretch");
      end else begin
         $display("FAIL linear_contrast_stretch");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/lcs_pkg.sv
hdl/lcs_req_if.sv
hdl/linear_contrast_stretch.sv
bench/tb_linear_contrast_stretch.sv
